@@ rtl/rse_pkg.sv @@
// Shared constants, types and GF(256) arithmetic for the Reed-Solomon encoder.
package rse_pkg;

    localparam int SYM_W = 8;
    localparam int CNT_W = 6;
    localparam int MAX_PARITY_DEF = 32;

    // Field polynomial x^8 + x^4 + x^3 + x^2 + 1 and the primitive element.
    localparam logic [SYM_W:0]   FIELD_POLY   = 9'h11D;
    localparam logic [SYM_W-1:0] ALPHA        = 8'h02;
    localparam logic [SYM_W-1:0] GF_ONE       = 8'h01;
    localparam logic [CNT_W-1:0] PARITY_RESET = 6'd16;

    typedef logic [SYM_W-1:0] t_sym;

    // One data beat handed from the input register to the datapath.
    typedef struct packed {
        logic fire;
        logic last;
        t_sym data;
    } t_step;

    // Carry-less multiply with reduction by the field polynomial.
    function automatic t_sym gf_mul(input t_sym x, input t_sym y);
        t_sym acc;
        t_sym a;
        acc = '0;
        a   = x;
        for (int n = 0; n < SYM_W; n++) begin
            if (y[n]) begin
                acc = acc ^ a;
            end
            a = a[SYM_W-1] ? ({a[SYM_W-2:0], 1'b0} ^ FIELD_POLY[SYM_W-1:0])
                           : {a[SYM_W-2:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

@@ rtl/rse_gen.sv @@
// Generator polynomial builder: multiplies in one root (x - alpha^i) per cycle.
module rse_gen #(
    parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rse_pkg::CNT_W-1:0]     i_p_eff,
    output rse_pkg::t_sym [MAX_PARITY:0]  o_gen,
    output logic                          o_busy
);

    rse_pkg::t_sym [MAX_PARITY:0] r_gen;
    rse_pkg::t_sym [MAX_PARITY:0] n_gen;
    rse_pkg::t_sym                r_root;
    logic [rse_pkg::CNT_W-1:0]    r_idx;
    logic                         r_busy;

    // All coefficients take one root step at once, each from its old lower neighbor.
    always_comb begin
        n_gen[0] = r_gen[0];
        for (int j = 1; j <= MAX_PARITY; j++) begin
            n_gen[j] = r_gen[j] ^ rse_pkg::gf_mul(r_gen[j-1], r_root);
        end
    end

    // Restart from g(x) = 1 on reset or a new parity count, then step until done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_gen    <= {{MAX_PARITY{rse_pkg::t_sym'(0)}}, rse_pkg::GF_ONE};
            r_root   <= rse_pkg::GF_ONE;
            r_idx    <= '0;
            r_busy   <= 1'b1;
        end else if (r_busy) begin
            if (r_idx == i_p_eff) begin
                r_busy <= 1'b0;
            end else begin
                r_gen  <= n_gen;
                r_root <= rse_pkg::gf_mul(r_root, rse_pkg::ALPHA);
                r_idx  <= r_idx + 1'b1;
            end
        end
    end

    assign o_gen  = r_gen;
    assign o_busy = r_busy;

endmodule

@@ rtl/rse_lfsr.sv @@
// Division register: parallel update of the remainder by one message byte per beat.
module rse_lfsr #(
    parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  rse_pkg::t_step                  i_step,
    input  rse_pkg::t_sym [MAX_PARITY:0]    i_gen,
    output rse_pkg::t_sym [MAX_PARITY-1:0]  o_next_rem
);

    rse_pkg::t_sym [MAX_PARITY-1:0] r_rem;
    rse_pkg::t_sym [MAX_PARITY-1:0] n_rem;
    rse_pkg::t_sym                  fb;

    // Shift toward degree zero and add the feedback times each coefficient.
    // Coefficients above the parity count are zero, so unused lanes stay zero.
    always_comb begin
        fb = i_step.data ^ r_rem[0];
        for (int j = 0; j < MAX_PARITY; j++) begin
            if (j + 1 < MAX_PARITY) begin
                n_rem[j] = r_rem[j+1] ^ rse_pkg::gf_mul(i_gen[j+1], fb);
            end else begin
                n_rem[j] = rse_pkg::gf_mul(i_gen[j+1], fb);
            end
        end
    end

    // The remainder is handed off and cleared on the last byte of a codeword.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_rem <= '0;
        end else if (i_step.fire) begin
            if (i_step.last) begin
                r_rem <= '0;
            end else begin
                r_rem <= n_rem;
            end
        end
    end

    assign o_next_rem = n_rem;

endmodule

@@ rtl/rse_emit.sv @@
// Output register and parity shift register that sends the remainder after the data.
module rse_emit #(
    parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rse_pkg::t_step                  i_step,
    input  logic [rse_pkg::CNT_W-1:0]       i_p_eff,
    input  rse_pkg::t_sym [MAX_PARITY-1:0]  i_par,
    input  logic                            i_ready,
    output logic                            o_free,
    output logic                            o_valid,
    output rse_pkg::t_sym                   o_code,
    output logic                            o_is_parity,
    output logic                            o_eoc
);

    logic                            r_valid;
    logic [rse_pkg::CNT_W-1:0]       r_left;
    rse_pkg::t_sym [MAX_PARITY-1:0]  r_par;
    rse_pkg::t_sym                   r_code;
    logic                            r_is_parity;
    logic                            r_eoc;
    logic                            slot;
    logic                            load_par;
    logic                            send_par;

    // The output register can take a beat when empty or being drained.
    assign slot     = !r_valid || i_ready;
    assign o_free   = slot && (r_left == '0);
    assign send_par = slot && (r_left != '0);
    assign load_par = i_step.fire && i_step.last && (i_p_eff != '0);

    // Control: output valid and the count of parity bytes still to send.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else begin
            if (i_step.fire || send_par) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (load_par) begin
                r_left <= i_p_eff;
            end else if (send_par) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // Payload: pass-through byte, or the highest remaining parity byte.
    always_ff @(posedge i_clk) begin
        if (i_step.fire) begin
            r_code      <= i_step.data;
            r_is_parity <= 1'b0;
            r_eoc       <= i_step.last && (i_p_eff == '0);
        end else if (send_par) begin
            r_code      <= r_par[0];
            r_is_parity <= 1'b1;
            r_eoc       <= (r_left == rse_pkg::CNT_W'(1));
        end
        if (load_par) begin
            r_par <= i_par;
        end else if (send_par) begin
            for (int j = 0; j < MAX_PARITY; j++) begin
                if (j + 1 < MAX_PARITY) begin
                    r_par[j] <= r_par[j+1];
                end else begin
                    r_par[j] <= '0;
                end
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_code      = r_code;
    assign o_is_parity = r_is_parity;
    assign o_eoc       = r_eoc;

endmodule

@@ rtl/reed_solomon_encoder_gf256_core.sv @@
// Top level of the systematic Reed-Solomon encoder over GF(256).
//
//  Channel  | Valid/Ready              | Payload
//  ---------+--------------------------+---------------------------------------
//  input    | i_in_valid / o_in_ready  | i_data_symbol, i_last_symbol
//  output   | o_out_valid / i_out_ready| o_code_symbol, o_is_parity,
//           |                          | o_end_of_codeword
//  config   | i_cfg_valid / o_cfg_ready| i_parity_count
//
// Data bytes go through at one beat per cycle while the output is not stalled,
// via the input register and then the output register. A byte marked last adds
// p parity beats from the parity shift register, likewise one per cycle, while
// the input register holds. After reset and after each parity count write, the
// generator builder runs with the input held not ready; p is the count saturated
// to MAX_PARITY. A stall on the output backs up through the input register.
module reed_solomon_encoder_gf256_core #(
    parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rse_pkg::CNT_W-1:0]   i_parity_count,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rse_pkg::SYM_W-1:0]   i_data_symbol,
    input  logic                        i_last_symbol,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rse_pkg::SYM_W-1:0]   o_code_symbol,
    output logic                        o_is_parity,
    output logic                        o_end_of_codeword
);

    logic [rse_pkg::CNT_W-1:0]       r_parity_count;
    logic [rse_pkg::CNT_W-1:0]       p_eff;
    logic                            cfg_write;
    logic                            r_in_valid;
    rse_pkg::t_sym                   r_in_data;
    logic                            r_in_last;
    logic                            in_accept;
    logic                            gen_busy;
    logic                            emit_free;
    rse_pkg::t_step                  step;
    rse_pkg::t_sym [MAX_PARITY:0]    gen;
    rse_pkg::t_sym [MAX_PARITY-1:0]  next_rem;

    // A new count restarts the generator build and the codeword.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity_count <= rse_pkg::PARITY_RESET;
        end else if (cfg_write) begin
            r_parity_count <= i_parity_count;
        end
    end

    // Counts above the storage depth saturate.
    assign p_eff = (r_parity_count > rse_pkg::CNT_W'(MAX_PARITY))
                 ? rse_pkg::CNT_W'(MAX_PARITY) : r_parity_count;

    // Input register: a beat moves on when the output side can take a data byte.
    assign step.fire  = r_in_valid && emit_free;
    assign step.last  = r_in_last;
    assign step.data  = r_in_data;
    assign o_in_ready = !gen_busy && (!r_in_valid || step.fire);
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step.fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_data_symbol;
            r_in_last <= i_last_symbol;
        end
    end

    rse_gen #(
        .MAX_PARITY (MAX_PARITY)
    ) u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_write),
        .i_p_eff (p_eff),
        .o_gen   (gen),
        .o_busy  (gen_busy)
    );

    rse_lfsr #(
        .MAX_PARITY (MAX_PARITY)
    ) u_lfsr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_write),
        .i_step     (step),
        .i_gen      (gen),
        .o_next_rem (next_rem)
    );

    rse_emit #(
        .MAX_PARITY (MAX_PARITY)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_p_eff     (p_eff),
        .i_par       (next_rem),
        .i_ready     (i_out_ready),
        .o_free      (emit_free),
        .o_valid     (o_out_valid),
        .o_code      (o_code_symbol),
        .o_is_parity (o_is_parity),
        .o_eoc       (o_end_of_codeword)
    );

endmodule
